[rtl/core/imd_pkg.sv]
// ----------------------------------------------------------------------------
// imd_pkg
// Shared constants, types and helpers for the integer matrix determinant unit.
// ----------------------------------------------------------------------------
package imd_pkg;

    localparam int MAX_ORDER   = 8;
    localparam int DATA_W      = 32;
    localparam int N_W         = 4;
    localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int ELEM_AW     = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int MASK_W      = MAX_ORDER;
    localparam int DP_DEPTH    = 1 << MASK_W;
    localparam int C_W         = $clog2(MAX_ORDER + 1);
    localparam int CI_W        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    // engine status toward the top level
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] det;
    } t_eng_stat;

    // size register to effective order: zero reads as one, large values clamp
    function automatic logic [N_W-1:0] order_clamp(input logic [N_W-1:0] raw);
        logic [N_W-1:0] res;
        res = raw;
        if (raw == '0) begin
            res = N_W'(1);
        end else if (raw > N_W'(MAX_ORDER)) begin
            res = N_W'(MAX_ORDER);
        end
        return res;
    endfunction

endpackage

[rtl/core/imd_ram.sv]
// ----------------------------------------------------------------------------
// imd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module imd_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/imd_engine.sv]
// ----------------------------------------------------------------------------
// imd_engine
// Cofactor expansion over column subsets. Minor values are kept in a RAM
// indexed by the set of used columns and are built from the largest set down.
// ----------------------------------------------------------------------------
module imd_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [imd_pkg::N_W-1:0]      i_n,
    input  logic                         i_ack,
    output logic [imd_pkg::ELEM_AW-1:0]  o_elem_raddr,
    input  logic [imd_pkg::DATA_W-1:0]   i_elem_rdata,
    output imd_pkg::t_eng_stat           o_stat
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MASK = 6'b000010,
        ST_COL  = 6'b000100,
        ST_WAIT = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    logic [imd_pkg::N_W-1:0]       r_n, n_n;
    logic [imd_pkg::MASK_W-1:0]    r_mask, n_mask;
    logic [imd_pkg::C_W-1:0]       r_k, n_k;
    logic [imd_pkg::C_W-1:0]       r_c, n_c;
    logic                          r_pos, n_pos;
    logic [imd_pkg::DATA_W-1:0]    r_acc, n_acc;
    logic [imd_pkg::DATA_W-1:0]    r_prod, n_prod;

    logic                          dp_we;
    logic [imd_pkg::MASK_W-1:0]    dp_waddr;
    logic [imd_pkg::DATA_W-1:0]    dp_wdata;
    logic [imd_pkg::MASK_W-1:0]    dp_raddr;
    logic [imd_pkg::DATA_W-1:0]    dp_rdata;
    logic [imd_pkg::C_W-1:0]       pop;
    logic [imd_pkg::MASK_W:0]      full_ext;
    logic [imd_pkg::MASK_W-1:0]    col_bit;
    logic [2*imd_pkg::DATA_W-1:0]  prod_full;
    logic [imd_pkg::C_W+imd_pkg::N_W:0] elem_idx;

    // minor value store
    imd_ram #(
        .DEPTH (imd_pkg::DP_DEPTH),
        .WIDTH (imd_pkg::DATA_W)
    ) u_dp_ram (
        .i_clk   (i_clk),
        .i_we    (dp_we),
        .i_waddr (dp_waddr),
        .i_wdata (dp_wdata),
        .i_raddr (dp_raddr),
        .o_rdata (dp_rdata)
    );

    // population count of the used-column set gives the row
    always_comb begin
        pop = '0;
        for (int i = 0; i < imd_pkg::MASK_W; i++) begin
            pop = pop + imd_pkg::C_W'(r_mask[i]);
        end
    end

    assign full_ext  = ({{imd_pkg::MASK_W{1'b0}}, 1'b1} << i_n) - 1'b1;
    assign col_bit   = imd_pkg::MASK_W'(1) << r_c[imd_pkg::CI_W-1:0];
    assign dp_raddr  = r_mask | col_bit;
    assign elem_idx  = (imd_pkg::C_W+imd_pkg::N_W+1)'(r_k)
                     * (imd_pkg::C_W+imd_pkg::N_W+1)'(r_n)
                     + (imd_pkg::C_W+imd_pkg::N_W+1)'(r_c);
    assign o_elem_raddr = elem_idx[imd_pkg::ELEM_AW-1:0];
    assign prod_full = i_elem_rdata * dp_rdata;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_mask   = r_mask;
        n_k      = r_k;
        n_c      = r_c;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_prod   = r_prod;
        dp_we    = 1'b0;
        dp_waddr = r_mask;
        dp_wdata = r_acc;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_n     = i_n;
                    n_mask  = full_ext[imd_pkg::MASK_W-1:0];
                    n_state = ST_MASK;
                end
            end
            ST_MASK: begin
                if (pop == imd_pkg::C_W'(r_n)) begin
                    // empty minor: value one
                    dp_we    = 1'b1;
                    dp_wdata = imd_pkg::DATA_W'(1);
                    n_mask   = r_mask - 1'b1;
                end else begin
                    n_k     = pop;
                    n_c     = '0;
                    n_acc   = '0;
                    n_pos   = 1'b0;
                    n_state = ST_COL;
                end
            end
            ST_COL: begin
                if (r_c == imd_pkg::C_W'(r_n)) begin
                    dp_we = 1'b1;
                    if (r_mask == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_mask  = r_mask - 1'b1;
                        n_state = ST_MASK;
                    end
                end else if (r_mask[r_c[imd_pkg::CI_W-1:0]]) begin
                    n_c = r_c + 1'b1;
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_prod  = prod_full[imd_pkg::DATA_W-1:0];
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_acc   = r_pos ? (r_acc - r_prod) : (r_acc + r_prod);
                n_pos   = ~r_pos;
                n_c     = r_c + 1'b1;
                n_state = ST_COL;
            end
            ST_DONE: begin
                if (i_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_mask <= n_mask;
        r_k    <= n_k;
        r_c    <= n_c;
        r_pos  <= n_pos;
        r_acc  <= n_acc;
        r_prod <= n_prod;
    end

    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_stat.det  = r_acc;

endmodule

[rtl/core/integer_matrix_determinant_unit.sv]
// ----------------------------------------------------------------------------
// integer_matrix_determinant_unit
// Loads an n by n matrix row-major, one element per item, and returns its
// determinant modulo 2^32 after the last element.
// ----------------------------------------------------------------------------
// Loading: one element per cycle into the element RAM while not busy.
// Compute: subset sweep over 2^n column sets. A used term passes through the
//   column, wait and accumulate states; a skipped column only advances.
// The result sits in an output register; input stalls while computing.
// Reset (synchronous, active low): size 1, load count 0, no result pending.
module integer_matrix_determinant_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [imd_pkg::N_W-1:0]        i_cfg_matrix_size,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [imd_pkg::DATA_W-1:0] i_element_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [imd_pkg::DATA_W-1:0] o_determinant
);

    logic [imd_pkg::N_W-1:0]     r_size;
    logic [imd_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_out_valid;
    logic [imd_pkg::DATA_W-1:0]  r_det;

    logic [imd_pkg::N_W-1:0]     n_eff;
    logic [imd_pkg::CNT_W-1:0]   total;
    logic [imd_pkg::CNT_W-1:0]   slot;
    logic [imd_pkg::CNT_W-1:0]   slot_nx;
    logic                        in_fire;
    logic                        last;
    logic                        ack;
    logic [imd_pkg::ELEM_AW-1:0] elem_raddr;
    logic [imd_pkg::DATA_W-1:0]  elem_rdata;
    imd_pkg::t_eng_stat          stat;

    assign n_eff   = imd_pkg::order_clamp(r_size);
    assign total   = imd_pkg::CNT_W'(n_eff) * imd_pkg::CNT_W'(n_eff);
    assign slot    = (r_cnt >= total) ? '0 : r_cnt;
    assign slot_nx = slot + 1'b1;
    assign last    = (slot_nx >= total);

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ~stat.busy;
    assign in_fire     = i_in_valid & o_in_ready;
    assign ack         = stat.done & (~r_out_valid | i_out_ready);

    // element store
    imd_ram #(
        .DEPTH (imd_pkg::STORE_DEPTH),
        .WIDTH (imd_pkg::DATA_W)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (slot[imd_pkg::ELEM_AW-1:0]),
        .i_wdata (i_element_value),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

    imd_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_fire & last),
        .i_n          (n_eff),
        .i_ack        (ack),
        .o_elem_raddr (elem_raddr),
        .i_elem_rdata (elem_rdata),
        .o_stat       (stat)
    );

    // size register and load count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= imd_pkg::N_W'(1);
            r_cnt  <= '0;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_matrix_size;
            r_cnt  <= '0;
        end else if (in_fire) begin
            r_cnt <= last ? '0 : slot_nx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ack) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ack) begin
            r_det <= stat.det;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_determinant = r_det;

endmodule
